[hw/rtl/l3bt_pkg.sv]
`timescale 1ns / 1ps

package l3bt_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETUP,
        PH_LOW,
        PH_HIGH
    } phase_t;

    // register indexes on the config port
    localparam logic REG_SETUP = 1'b0;
    localparam logic REG_HALF  = 1'b1;

    localparam int         QUEUE_DEPTH   = 2;
    localparam logic [7:0] SETUP_RESET   = 8'd4;
    localparam logic [7:0] HALF_RESET    = 8'd4;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // one classified item handed from front to back
    typedef struct packed {
        logic       is_start;
        logic       is_address;
        logic [7:0] tx_byte;
    } op_t;

    // result item; mode ends up in the lowest bit
    typedef struct packed {
        logic start_ignored;
        logic busy_res;
        logic l3_data;
        logic l3_clock;
        logic l3_mode;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        at_least_one = (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

[hw/rtl/l3bt_front.sv]
`timescale 1ns / 1ps

module l3bt_front #(
    parameter int QDEPTH = l3bt_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic                in_is_address,
    input  logic [7:0]          in_tx_byte,
    output logic                op_valid,
    output l3bt_pkg::op_t       op,
    input  logic                op_pop,
    output l3bt_pkg::q_status_t status
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

    l3bt_pkg::op_t    queue_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    l3bt_pkg::op_t    op_in;
    logic             push;
    logic             pop;

    // a tick with cmd low is a plain tick; byte and flag matter only on a start
    assign op_in.is_start   = in_cmd;
    assign op_in.is_address = in_is_address;
    assign op_in.tx_byte    = in_tx_byte;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign in_ready     = !status.full;
    assign op_valid     = !status.empty;
    assign op           = queue_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = op_pop && op_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[hw/rtl/l3bt_back.sv]
`timescale 1ns / 1ps

module l3bt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     setup_ticks,
    input  logic [7:0]     half_period_ticks,
    input  logic           op_valid,
    input  l3bt_pkg::op_t  op,
    output logic           op_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output l3bt_pkg::res_t res
);

    l3bt_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       shift_reg, shift_next;
    logic [3:0]       bits_reg, bits_next;
    logic [7:0]       tick_reg, tick_next;
    logic             mode_reg, mode_next;
    logic             out_valid_reg, out_valid_next;
    l3bt_pkg::res_t   res_reg, res_next;
    logic             take;

    // output register frees up when empty or being taken this cycle
    assign take      = op_valid && (!out_valid_reg || out_ready);
    assign op_pop    = take;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_next      = bits_reg;
        tick_next      = tick_reg;
        mode_next      = mode_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            out_valid_next         = 1'b1;
            res_next.l3_mode       = 1'b1;
            res_next.l3_clock      = 1'b1;
            res_next.l3_data       = 1'b0;
            res_next.busy_res      = 1'b0;
            res_next.start_ignored = 1'b0;

            if (op.is_start)
            begin
                if (phase_reg != l3bt_pkg::PH_IDLE)
                begin
                    res_next.start_ignored = 1'b1;
                end
                else
                begin
                    shift_next = op.tx_byte;
                    bits_next  = l3bt_pkg::BITS_PER_BYTE;
                    mode_next  = !op.is_address;
                    phase_next = l3bt_pkg::PH_SETUP;
                    tick_next  = l3bt_pkg::at_least_one(setup_ticks);
                end
            end

            // the start tick itself is the first setup tick
            if (phase_next != l3bt_pkg::PH_IDLE)
            begin
                res_next.busy_res = 1'b1;
                res_next.l3_mode  = mode_next;
                if (phase_next != l3bt_pkg::PH_SETUP)
                begin
                    res_next.l3_clock = (phase_next == l3bt_pkg::PH_HIGH);
                    res_next.l3_data  = shift_next[0];
                end
                if (tick_next <= 8'd1)
                begin
                    tick_next = 8'd0;
                    case (phase_next)
                        l3bt_pkg::PH_SETUP:
                        begin
                            phase_next = l3bt_pkg::PH_LOW;
                            tick_next  = l3bt_pkg::at_least_one(half_period_ticks);
                        end
                        l3bt_pkg::PH_LOW:
                        begin
                            phase_next = l3bt_pkg::PH_HIGH;
                            tick_next  = l3bt_pkg::at_least_one(half_period_ticks);
                        end
                        l3bt_pkg::PH_HIGH:
                        begin
                            shift_next = {1'b0, shift_next[7:1]};
                            bits_next  = bits_next - 4'd1;
                            if (bits_next == 4'd0)
                            begin
                                phase_next = l3bt_pkg::PH_IDLE;
                                mode_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next = l3bt_pkg::PH_LOW;
                                tick_next  = l3bt_pkg::at_least_one(half_period_ticks);
                            end
                        end
                        default:
                        begin
                            phase_next = l3bt_pkg::PH_IDLE;
                        end
                    endcase
                end
                else
                begin
                    tick_next = tick_next - 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= l3bt_pkg::PH_IDLE;
            shift_reg     <= 8'd0;
            bits_reg      <= 4'd0;
            tick_reg      <= 8'd0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            tick_reg      <= tick_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[hw/rtl/l3_bus_byte_transmitter.sv]
`timescale 1ns / 1ps
// A tick item accepted at s_tdata passes through the front queue and then the output register
// before its line levels show at m_tdata.
// Throughput: one item per clock; the queue and the output register let either side stall.
// Reset (rst_n low, async): no transfer, queue and output empty, result register not reset,
// setup_ticks and half_period_ticks back to 4.
module l3_bus_byte_transmitter #(
    parameter int QDEPTH = l3bt_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] tx_byte
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] is_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] l3_mode, [1] l3_clock, [2] l3_data,
                                   // [3] busy_res, [4] start_ignored, [7:5] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]          setup_reg;
    logic [7:0]          half_reg;
    logic                cfg_write;
    logic                op_valid;
    logic                op_pop;
    l3bt_pkg::op_t       op;
    l3bt_pkg::q_status_t q_status;
    l3bt_pkg::res_t      res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= l3bt_pkg::SETUP_RESET;
            half_reg  <= l3bt_pkg::HALF_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                l3bt_pkg::REG_SETUP: setup_reg <= pwdata[7:0];
                l3bt_pkg::REG_HALF:  half_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            l3bt_pkg::REG_SETUP: prdata = {24'd0, setup_reg};
            l3bt_pkg::REG_HALF:  prdata = {24'd0, half_reg};
            default:             prdata = 32'd0;
        endcase
    end

    l3bt_front #(
        .QDEPTH(QDEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser[0]),
        .in_is_address(s_tuser[1]),
        .in_tx_byte   (s_tdata),
        .op_valid     (op_valid),
        .op           (op),
        .op_pop       (op_pop),
        .status       (q_status)
    );

    l3bt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .setup_ticks      (setup_reg),
        .half_period_ticks(half_reg),
        .op_valid         (op_valid),
        .op               (op),
        .op_pop           (op_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .res              (res)
    );

    assign m_tdata = {3'b000, res};

    // an idle tick drives idle lines and never flags a dropped start
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[0] && m_tdata[1] && !m_tdata[2] && !m_tdata[4])
        else $error("idle result with non-idle lines");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // queue can only fill on a cycle that took an item
    a_fill_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_status.full) |-> $past(s_tvalid))
        else $error("queue filled without an input item");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
